@@ rtl/core/itda_pkg.sv @@
// itda_pkg: shared widths, character codes, controller states and the
// command/status structs passed between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itda_pkg;

  // Width of the signed input word.
  localparam int unsigned VALUE_BITS = 32;
  // Decimal digits needed for the magnitude: floor(VALUE_BITS*log10(2)) + 1.
  localparam int unsigned NUM_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int unsigned BCD_BITS   = 4 * NUM_DIGITS;
  localparam int unsigned STEP_W     = $clog2(VALUE_BITS);
  localparam int unsigned CNT_W      = $clog2(NUM_DIGITS + 1);

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_SIGN,
    S_EMIT
  } itda_state_e;

  typedef struct packed {
    logic load;        // capture a new value and clear the BCD register
    logic conv_step;   // one shift-add-3 step
    logic skip_digit;  // drop a leading zero digit
    logic emit_sign;   // load '-' into the output register
    logic emit_digit;  // load the top digit into the output register and shift
  } itda_cmd_t;

  typedef struct packed {
    logic conv_done;   // the step now running is the final one
    logic top_zero;    // the most significant remaining digit is zero
    logic one_left;    // only one digit remains
    logic neg;         // the captured value was negative
  } itda_status_t;

endpackage

`default_nettype wire

@@ rtl/core/int_to_decimal_ascii_core.sv @@
// int_to_decimal_ascii_core: top level joining the controller and datapath.
// Depends on itda_pkg, itda_ctrl and itda_datapath.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   Direction  Handshake                  Payload
//  input     in         in_valid_i / in_ready_o    value_i (signed, VALUE_BITS)
//  output    out        out_valid_o / out_ready_i  character_o (8), last_o (1)
//
// A request is accepted in the idle state and then takes VALUE_BITS (32)
// shift-add-3 steps of the double-dabble register. The leading digit is
// then inspected, and leading zeros are dropped one at a time (up to
// NUM_DIGITS-1, 9) before the characters are sent (1 to 11). Dropped zeros
// and digits sent always add up to NUM_DIGITS (10). The shared BCD register
// keeps a new request out until the final character of the previous one has
// been loaded for output. Reset clears only the state machine, the counters
// and the output valid flag. While a character is waiting and the output is
// stalled, the sequencer waits, and a new request is accepted while the
// final character of the previous one is still waiting to be taken.

module int_to_decimal_ascii_core import itda_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic [VALUE_BITS-1:0] value_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [7:0]            character_o,
  output      logic                  last_o
);

  itda_cmd_t    cmd;
  itda_status_t status;

  // The controller sequences load, conversion, zero skipping and emission.
  itda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the magnitude, the BCD digits and the output character.
  itda_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/itda_datapath.sv @@
// itda_datapath: magnitude register, double-dabble BCD register, counters
// and the output character register.
// Depends on itda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itda_datapath import itda_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [VALUE_BITS-1:0]   value_i,
  input  wire itda_cmd_t               cmd_i,
  output      itda_status_t            status_o,
  output      logic [7:0]              character_o,
  output      logic                    last_o
);

  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [BCD_BITS-1:0]   bcd_q, bcd_d, bcd_adj;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  neg_q, neg_d;
  logic [7:0]            char_q, char_d;
  logic                  last_q, last_d;
  logic [3:0]            top_digit;

  assign top_digit = bcd_q[BCD_BITS-1 -: 4];

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    mag_d  = mag_q;
    bcd_d  = bcd_q;
    step_d = step_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    char_d = char_q;
    last_d = last_q;
    if (cmd_i.load) begin
      neg_d  = value_i[VALUE_BITS-1];
      mag_d  = value_i[VALUE_BITS-1] ? (~value_i + VALUE_BITS'(1)) : value_i;
      bcd_d  = '0;
      step_d = STEP_W'(VALUE_BITS - 1);
      cnt_d  = CNT_W'(NUM_DIGITS);
    end else if (cmd_i.conv_step) begin
      bcd_d  = {bcd_adj[BCD_BITS-2:0], mag_q[VALUE_BITS-1]};
      mag_d  = {mag_q[VALUE_BITS-2:0], 1'b0};
      if (step_q != '0) begin
        step_d = step_q - STEP_W'(1);
      end
    end else if (cmd_i.skip_digit || cmd_i.emit_digit) begin
      bcd_d = {bcd_q[BCD_BITS-5:0], 4'd0};
      cnt_d = cnt_q - CNT_W'(1);
    end
    if (cmd_i.emit_sign) begin
      char_d = ASCII_MINUS;
      last_d = 1'b0;
    end else if (cmd_i.emit_digit) begin
      char_d = ASCII_ZERO + {4'd0, top_digit};
      last_d = (cnt_q == CNT_W'(1));
    end
  end

  // Counters are cleared on reset; the data registers need no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      cnt_q  <= '0;
    end else begin
      step_q <= step_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign status_o.conv_done = (step_q == '0);
  assign status_o.top_zero  = (top_digit == 4'd0);
  assign status_o.one_left  = (cnt_q == CNT_W'(1));
  assign status_o.neg       = neg_q;
  assign character_o        = char_q;
  assign last_o             = last_q;

endmodule

`default_nettype wire

@@ rtl/core/itda_ctrl.sv @@
// itda_ctrl: sequencing state machine and output valid flag.
// Depends on itda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itda_ctrl import itda_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output      logic         in_ready_o,
  output      logic         out_valid_o,
  input  wire logic         out_ready_i,
  input  wire itda_status_t status_i,
  output      itda_cmd_t    cmd_o
);

  itda_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CONV;
      end
      S_CONV: begin
        if (status_i.conv_done) state_d = S_SKIP;
      end
      S_SKIP: begin
        if (!status_i.top_zero || status_i.one_left) begin
          state_d = status_i.neg ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (out_free) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free && status_i.one_left) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_CONV: cmd_o.conv_step = 1'b1;
      S_SKIP: cmd_o.skip_digit = status_i.top_zero && !status_i.one_left;
      S_SIGN: cmd_o.emit_sign = out_free;
      S_EMIT: cmd_o.emit_digit = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    if (cmd_o.emit_sign || cmd_o.emit_digit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // The output register is only overwritten once its character has gone.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_sign || cmd_o.emit_digit) |-> (!out_valid_q || out_ready_i))
    else $error("character loaded over one not yet taken");

  // The final conversion step always leads to the leading-zero skip.
  a_conv_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CONV && status_i.conv_done) |=> (state_q == S_SKIP))
    else $error("conversion did not end after its last step");

  // Emitting the final digit returns the controller to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_digit && status_i.one_left) |=> (state_q == S_IDLE && out_valid_q))
    else $error("final digit did not close the run");

endmodule

`default_nettype wire

@@ verif/tb_int_to_decimal_ascii_core.sv @@
// Self-checking testbench for int_to_decimal_ascii_core: signed integers in, decimal ASCII out.
// Depends on itda_pkg and the core. The expected text of each request is typed
// in or predicted here, and compared with every character that the core hands over.
`timescale 1ns / 1ps

module tb_int_to_decimal_ascii_core;
  import itda_pkg::*;

  // The longest text is a sign followed by every digit of the magnitude.
  localparam int MAX_CHARS      = NUM_DIGITS + 1;
  localparam int NUM_DIRECTED   = 22;
  localparam int RANDOM_PER_SET = 100;
  // Cycles without a single handshake on either channel before we give up.
  // The internal work of a request and the long output hold-off below both
  // fit well inside this limit.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_LEN   = 300;
  localparam int DRAIN_CYCLES   = 60;
  localparam int MAX_REPORTS    = 50;

  typedef logic [8*MAX_CHARS-1:0] text_t;

  // One expected character of the output text.
  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  // One row of the directed stimulus. The text is right-justified, with NUL
  // padding at the front. A text of all zeros leaves the row to the predictor.
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    text_t                 text;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{32'd0,          "0"},
    '{32'd1,          "1"},
    '{-32'sd1,        "-1"},
    '{32'd9,          "9"},
    '{32'd10,         "10"},
    '{-32'sd10,       "-10"},
    '{32'd99,         "99"},
    '{32'd100,        "100"},
    '{-32'sd9,        "-9"},
    '{32'h7fff_ffff,  "2147483647"},
    '{32'h8000_0000,  "-2147483648"},
    '{32'h8000_0001,  "-2147483647"},
    '{32'd999999999,  "999999999"},
    '{32'd1000000000, "1000000000"},
    '{-32'sd999999999, "-999999999"},
    '{-32'sd1000000000, "-1000000000"},
    '{32'd1000000,    "1000000"},
    '{32'h5555_5555,  '0},
    '{32'haaaa_aaaa,  '0},
    '{32'h0f0f_0f0f,  '0},
    '{32'hf0f0_f0f0,  '0},
    '{32'd123456789,  '0}
  };

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [VALUE_BITS-1:0] value_i     = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [7:0]            character_o;
  logic                  last_o;

  // Expected characters, oldest first, across every request in flight.
  text_char_t pending_chars [$];
  // A typed-in text for each request offered, or zero where the predictor decides.
  text_t      golden_q [$];

  int          error_count     = 0;
  int unsigned requests_done   = 0;
  int unsigned negatives_done  = 0;
  int unsigned chars_checked   = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  // Set by the stimulus process. The receiver counts it down by itself.
  int unsigned hold_off_left   = 0;

  int_to_decimal_ascii_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("tb_int_to_decimal_ascii_core: mismatch at %0t ns: %s", $time, what);
    end
  endtask

  // Works out the decimal text of one request and queues its characters:
  // a minus sign for negative values, then the magnitude without leading zeros.
  // The magnitude is taken unsigned, so the most negative value needs no special path.
  function automatic void queue_decimal_text(input logic [VALUE_BITS-1:0] value);
    logic [VALUE_BITS-1:0] magnitude;
    logic [3:0]            digit;
    logic [3:0]            digits [$];
    logic                  negative;
    negative  = value[VALUE_BITS-1];
    magnitude = negative ? -value : value;
    do begin
      digits.push_front(4'(magnitude % 10));
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    if (negative) begin
      pending_chars.push_back('{ASCII_MINUS, 1'b0});
    end
    while (digits.size() != 0) begin
      digit = digits.pop_front();
      pending_chars.push_back('{8'(ASCII_ZERO + digit), digits.size() == 0});
    end
  endfunction

  // Queues a typed-in text. NUL bytes at the front are padding, and byte zero
  // always holds the final character.
  function automatic void queue_typed_text(input text_t text);
    for (int i = MAX_CHARS - 1; i >= 0; i--) begin
      if (text[8*i +: 8] != 8'd0) begin
        pending_chars.push_back('{text[8*i +: 8], i == 0});
      end
    end
  endfunction

  // Offers one request. The task starts and ends at a falling edge, so
  // in_valid_i receives exactly one assignment in each time step.
  task automatic send_request(input logic [VALUE_BITS-1:0] value, input text_t text);
    golden_q.push_back(text);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Random values are spread over the full word, over shortened magnitudes
  // of either sign, and over the edges of each decade, where the digit count changes.
  function automatic logic [VALUE_BITS-1:0] random_value();
    logic [VALUE_BITS-1:0] v;
    int unsigned           decade;
    v = $urandom;
    case ($urandom_range(2))
      0: ;
      1: begin
        v = v >> $urandom_range(VALUE_BITS - 1);
        if ($urandom_range(1) == 1) v = -v;
      end
      default: begin
        decade = 1;
        repeat ($urandom_range(9)) decade = decade * 10;
        v = VALUE_BITS'(decade + $urandom_range(2) - 1);
        if ($urandom_range(1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic run_random_set(input int unsigned idle_pct, input int unsigned stall_pct);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    repeat (RANDOM_PER_SET) send_request(random_value(), '0);
  endtask

  // Receiver: at each falling edge it chooses whether to take a character.
  // A pending hold-off overrides the random stall.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        out_ready_i   <= 1'b0;
        hold_off_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Each accepted request queues its expected text, using the typed-in text
  // where the row gives one.
  always @(posedge clk_i) begin
    text_t text;
    if (rst_ni && in_valid_i && in_ready_o) begin
      text = golden_q.pop_front();
      requests_done++;
      if (value_i[VALUE_BITS-1]) negatives_done++;
      if (text != '0) begin
        queue_typed_text(text);
      end else begin
        queue_decimal_text(value_i);
      end
    end
  end

  // Each character handed over is compared with the oldest expectation.
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("character 0x%02h (last %b) with nothing expected",
                                  character_o, last_o));
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (character_o !== want.character) begin
          report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                    character_o, want.character));
        end
        if (last_o !== want.last) begin
          report_mismatch($sformatf("last %b on character 0x%02h, expected %b",
                                    last_o, want.character, want.last));
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a request or a character.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_int_to_decimal_ascii_core: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_int_to_decimal_ascii_core: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows first, with no idling on either side.
    for (int row = 0; row < NUM_DIRECTED; row++) begin
      send_request(DIRECTED_ROWS[row].value, DIRECTED_ROWS[row].text);
    end

    // A long hold-off on the output while requests arrive back to back, so
    // the core fills up and has to stall its input. The set then continues
    // without idling once the receiver resumes.
    hold_off_left = HOLD_OFF_LEN;
    run_random_set(0, 0);
    run_random_set(65, 0);
    run_random_set(0, 65);
    run_random_set(34, 34);
    in_valid_i <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk_i);
    // Allow for any stray character that might still come out.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb_int_to_decimal_ascii_core: %0d requests (%0d negative), %0d characters compared",
             requests_done, negatives_done, chars_checked);
    $display("tb_int_to_decimal_ascii_core: paced free, sender idle, output stalled, both, and one long hold-off");
    if (error_count == 0) begin
      $display("tb_int_to_decimal_ascii_core: done, clean");
    end else begin
      $display("tb_int_to_decimal_ascii_core: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/itda_pkg.sv
rtl/core/itda_datapath.sv
rtl/core/itda_ctrl.sv
rtl/core/int_to_decimal_ascii_core.sv
verif/tb_int_to_decimal_ascii_core.sv
